[hw/rtl/dpb_pkg.sv]
// ----------------------------------------------------------------------------
// dpb_pkg: shared types and constants for depth-to-point back-projection
// Holds field widths, register indexes, reset values and the job record
// passed from the pixel front end to the projection back end.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int CntW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);

  localparam int DepthW = 16;
  localparam int FocW   = 20;
  localparam int ImgW   = 13;
  localparam int PtW    = 32;

  // configuration register indexes
  localparam logic [2:0] REG_FOCAL_X     = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y     = 3'd1;
  localparam logic [2:0] REG_CENTER_X    = 3'd2;
  localparam logic [2:0] REG_CENTER_Y    = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd4;

  localparam logic [FocW-1:0] FOCAL_X_RST  = 20'd146001;
  localparam logic [FocW-1:0] FOCAL_Y_RST  = 20'd146002;
  localparam logic [FocW-1:0] CENTER_X_RST = 20'd80621;
  localparam logic [FocW-1:0] CENTER_Y_RST = 20'd58519;
  localparam logic [ImgW-1:0] IMG_W_RST    = 13'd640;

  // diff = pos*256 - center: fits in 33 signed bits
  localparam int DiffW = 33;
  // |num| = |diff| * z * 16 < 2^32 * 2^16 * 2^4 = 2^52
  localparam int MagW  = 53;
  localparam int QW    = MagW;

  typedef struct packed {
    logic [CntW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [DepthW-1:0] depth;
    logic              last;
  } dpb_job_t;

  typedef struct packed {
    logic [PtW-1:0]    px;
    logic [PtW-1:0]    py;
    logic [DepthW-1:0] pz;
    logic              pvalid;
    logic              fend;
  } dpb_res_t;

endpackage

[hw/rtl/dpb_front.sv]
// ----------------------------------------------------------------------------
// dpb_front: pixel front end
// Counts column and row, drops zero-depth pixels that are not frame end,
// and pushes one job per surviving pixel into the queue.
// ----------------------------------------------------------------------------
module dpb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dpb_pkg::DepthW-1:0] in_depth,
  input  logic                      in_last,
  input  logic [dpb_pkg::ImgW-1:0]  row_len,
  output logic                      push,
  output dpb_pkg::dpb_job_t         push_job,
  input  logic                      q_full
);
  import dpb_pkg::*;

  logic [CntW-1:0] col_r, col_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic            acc;
  logic [CntW:0]   col_inc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = acc && ((in_depth != '0) || in_last);

  assign push_job.col   = col_r;
  assign push_job.row   = row_r;
  assign push_job.depth = in_depth;
  assign push_job.last  = in_last;

  // advance raster position
  always_comb begin
    col_inc = {1'b0, col_r} + 1'b1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (in_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if ((col_inc >= row_len) ||
                   (col_inc >= (CntW+1)'(MaxWidth))) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

[hw/rtl/dpb_queue.sv]
// ----------------------------------------------------------------------------
// dpb_queue: two-entry job queue
// Decouples the pixel front end from the projection back end.
// ----------------------------------------------------------------------------
module dpb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dpb_pkg::dpb_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output dpb_pkg::dpb_job_t head
);
  import dpb_pkg::*;

  dpb_job_t  mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  // store pushed job
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  // move pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hw/rtl/dpb_divider.sv]
// ----------------------------------------------------------------------------
// dpb_divider: unsigned restoring divider
// One quotient bit per cycle; quotient width is the numerator width.
// ----------------------------------------------------------------------------
module dpb_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [dpb_pkg::MagW-1:0] num,
  input  logic [dpb_pkg::FocW-1:0] den,
  output logic                     done,
  output logic [dpb_pkg::QW-1:0]   quo
);
  import dpb_pkg::*;

  localparam int StW = $clog2(MagW + 1);

  logic [MagW-1:0] q_r;
  logic [FocW:0]   rem_r;
  logic [FocW-1:0] den_r;
  logic [StW-1:0]  left_r;
  logic            busy_r;
  logic [FocW+1:0] trial;

  assign quo  = q_r;
  assign done = busy_r && (left_r == '0);

  assign trial = {rem_r, q_r[MagW-1]} - {2'b00, den_r};

  // shift one numerator bit into the remainder per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      left_r <= StW'(MagW);
    end else if (busy_r) begin
      if (left_r == '0) busy_r <= 1'b0;
      else left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r && (left_r != '0)) begin
      if (!trial[FocW+1]) begin
        rem_r <= trial[FocW:0];
        q_r   <= {q_r[MagW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[FocW-1:0], q_r[MagW-1]};
        q_r   <= {q_r[MagW-2:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/dpb_back.sv]
// ----------------------------------------------------------------------------
// dpb_back: projection back end
// Pops a job; for nonzero depth forms both numerators, divides x then y on a
// shared divider and saturates; then loads the output register.
// ----------------------------------------------------------------------------
module dpb_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     not_empty,
  input  dpb_pkg::dpb_job_t        head,
  output logic                     pop,
  input  logic [dpb_pkg::FocW-1:0] focal_x,
  input  logic [dpb_pkg::FocW-1:0] focal_y,
  input  logic [dpb_pkg::FocW-1:0] center_x,
  input  logic [dpb_pkg::FocW-1:0] center_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dpb_pkg::dpb_res_t        out_res
);
  import dpb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUBX = 3'd1;
  localparam logic [2:0] S_MULX = 3'd2;
  localparam logic [2:0] S_DIVX = 3'd3;
  localparam logic [2:0] S_SUBY = 3'd4;
  localparam logic [2:0] S_MULY = 3'd5;
  localparam logic [2:0] S_DIVY = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]        st_r, st_nxt;
  dpb_job_t          job_r;
  logic              sel_y;
  logic [DiffW-1:0]  diff;
  logic              neg;
  logic [DiffW-1:0]  dmag;
  logic [DiffW-1:0]  dmag_r;
  logic [MagW-1:0]   prod;
  logic [MagW-1:0]   mag_r;
  logic              neg_r;
  logic [PtW-1:0]    qx_r;
  logic              start_r;
  logic              dv_done;
  logic [QW-1:0]     dv_quo;
  logic [FocW-1:0]   den;
  logic [PtW-1:0]    sat;
  logic              ov_r;
  dpb_res_t          res_r;

  assign pop       = (st_r == S_IDLE) && not_empty;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign sel_y     = st_r inside {S_SUBY, S_MULY, S_DIVY, S_OUT};

  // select axis operands
  always_comb begin
    if (!sel_y) begin
      diff = {{(DiffW-CntW-8){1'b0}}, job_r.col, 8'd0} - {{(DiffW-FocW){1'b0}}, center_x};
      den  = focal_x;
    end else begin
      diff = {{(DiffW-RowW-8){1'b0}}, job_r.row, 8'd0} - {{(DiffW-FocW){1'b0}}, center_y};
      den  = focal_y;
    end
    neg  = diff[DiffW-1];
    dmag = neg ? (~diff + 1'b1) : diff;
  end

  // |diff| * z; the times-16 scale is a shift on load
  assign prod = MagW'(dmag_r) * MagW'(job_r.depth);

  // saturate signed quotient; zero focal behaves as infinite magnitude
  always_comb begin
    logic big;
    big = (den == '0) || (dv_quo[QW-1:PtW-1] != '0);
    if (mag_r == '0)      sat = '0;
    else if (!neg_r)      sat = big ? 32'h7FFF_FFFF : dv_quo[PtW-1:0];
    else if (big)         sat = 32'h8000_0000;
    else                  sat = ~dv_quo[PtW-1:0] + 1'b1;
  end

  dpb_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (mag_r),
    .den   (den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // sequence one job
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (pop) st_nxt = (head.depth != '0) ? S_SUBX : S_OUT;
      S_SUBX: st_nxt = S_MULX;
      S_MULX: st_nxt = S_DIVX;
      S_DIVX: if (dv_done) st_nxt = S_SUBY;
      S_SUBY: st_nxt = S_MULY;
      S_MULY: st_nxt = S_DIVY;
      S_DIVY: if (dv_done) st_nxt = S_OUT;
      S_OUT:  if (!ov_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ov_r    <= 1'b0;
      start_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      // start the divider once the numerator register is loaded
      start_r <= (st_r == S_MULX) || (st_r == S_MULY);
      if (st_r == S_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (pop) job_r <= head;
      S_SUBX, S_SUBY: begin
        dmag_r <= dmag;
        neg_r  <= neg;
      end
      S_MULX, S_MULY: mag_r <= {prod[MagW-5:0], 4'd0};
      S_DIVX: if (dv_done) qx_r <= sat;
      S_DIVY: ;
      S_OUT: if (!ov_r || out_ready) begin
        res_r.px     <= (job_r.depth != '0) ? qx_r : '0;
        res_r.py     <= (job_r.depth != '0) ? sat : '0;
        res_r.pz     <= job_r.depth;
        res_r.pvalid <= (job_r.depth != '0);
        res_r.fend   <= job_r.last;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/depth_to_point_backprojection.sv]
// ----------------------------------------------------------------------------
// depth_to_point_backprojection: pinhole depth image back-projection
//
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata depth[15:0], tlast frame_last
// out_    | out | out_tvalid/tready  | tdata x,y,z; tuser point_valid,frame_end
// cfg_    | in  | cfg_valid/ready    | cfg_index[2:0], cfg_data[19:0]
//
// A point holds the back end from accept to out_tvalid for two passes of the
// shared bit-serial divider (load, 53 quotient bits, done) plus its setup and
// output states. A frame-end marker skips the divider and goes straight to the
// output state; other zero-depth pixels are dropped at accept.
// Synchronous active-low reset restores register defaults and clears counters.
// A stalled result holds the back end; the two-entry queue then fills and
// in_tready drops.
// ----------------------------------------------------------------------------
module depth_to_point_backprojection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // depth[15:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // point_x[31:0], point_y[63:32], point_z[79:64]
  output logic [1:0]  out_tuser,  // point_valid[0], frame_end[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import dpb_pkg::*;

  logic [FocW-1:0] fx_r, fy_r, cx_r, cy_r;
  logic [ImgW-1:0] iw_r;
  logic            push, full, pop, nempty;
  dpb_job_t        pjob, head;
  dpb_res_t        res;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= FOCAL_X_RST;
      fy_r <= FOCAL_Y_RST;
      cx_r <= CENTER_X_RST;
      cy_r <= CENTER_Y_RST;
      iw_r <= IMG_W_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:     fx_r <= cfg_data;
        REG_FOCAL_Y:     fy_r <= cfg_data;
        REG_CENTER_X:    cx_r <= cfg_data;
        REG_CENTER_Y:    cy_r <= cfg_data;
        REG_IMAGE_WIDTH: iw_r <= cfg_data[ImgW-1:0];
        default: ;
      endcase
    end
  end

  dpb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_depth(in_tdata), .in_last(in_tlast), .row_len(iw_r),
    .push(push), .push_job(pjob), .q_full(full)
  );

  dpb_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(pjob), .full(full),
    .pop(pop), .not_empty(nempty), .head(head)
  );

  dpb_back u_back (
    .clk(clk), .rst_n(rst_n), .not_empty(nempty), .head(head), .pop(pop),
    .focal_x(fx_r), .focal_y(fy_r), .center_x(cx_r), .center_y(cy_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.pz, res.py, res.px};
  assign out_tuser = {res.fend, res.pvalid};

endmodule

[hw/rtl/dpb_checker.sv]
// ----------------------------------------------------------------------------
// dpb_checker: port-level checks for depth_to_point_backprojection
// Watches the output stream port and flags handshake and payload slips.
// ----------------------------------------------------------------------------
module dpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed under stall");

  // a marker beat carries zero payload and frame end
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[1] && out_tdata == '0)
    else $error("bad frame-end marker");

  // a point beat carries nonzero depth
  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[79:64] != 16'd0)
    else $error("point with zero depth");

endmodule

bind depth_to_point_backprojection dpb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: depth-to-point back-projection check
// Drives depth pixels with frame marks, predicts each projected point from
// its own copy of the intrinsics and raster counters, and compares every
// result beat field by field. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import dpb_pkg::*;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] pz;
    logic        pvalid;
    logic        fend;
  } point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // predictor state
  logic [19:0] fx, fy, cx, cy;
  logic [12:0] img_w;
  int unsigned col_cnt, row_cnt;

  point_t expected_points[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     hold_off = 1'b0;
  logic   rx_took = 1'b0;
  int     rx_wait = 0;

  depth_to_point_backprojection uut (.*);

  always #1 clk = ~clk;

  // abort on runaway
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 500000) begin
      $display("FAIL depth_to_point_backprojection");
      $finish;
    end
  end

  // (pos*256 - center) * z * 16 / focal, truncated, saturated to 32 bits
  function automatic logic [31:0] project_axis(int unsigned pos, logic [19:0] center,
                                               logic [15:0] z, logic [19:0] focal);
    longint diff, num, q;
    diff = longint'(pos) * 256 - longint'(center);
    num  = diff * longint'(z) * 16;
    if (focal == 0) q = (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
    else q = num / longint'(focal);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic void predict_pixel(logic [15:0] z, logic last);
    point_t p;
    if (z != 0) begin
      p.px = project_axis(col_cnt, cx, z, fx);
      p.py = project_axis(row_cnt, cy, z, fy);
      p.pz = z; p.pvalid = 1'b1; p.fend = last;
      expected_points = {expected_points, p};
    end else if (last) begin
      p.px = '0; p.py = '0; p.pz = '0; p.pvalid = 1'b0; p.fend = 1'b1;
      expected_points = {expected_points, p};
    end
    if (last) begin
      col_cnt = 0; row_cnt = 0;
    end else if (col_cnt + 1 >= img_w || col_cnt + 1 >= MaxWidth) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= MaxHeight) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  // send one pixel beat after a random gap; valid stays up until the next
  // beat or until the sender goes idle
  task automatic send_pixel(logic [15:0] z, logic last);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= z; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_pixel(z, last);
    @(negedge clk);
  endtask

  // drain, then write one register while idle
  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    in_tvalid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (150) @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FOCAL_X:     fx = val;
      REG_FOCAL_Y:     fy = val;
      REG_CENTER_X:    cx = val;
      REG_CENTER_Y:    cy = val;
      REG_IMAGE_WIDTH: img_w = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: idle at random after each taken beat, long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (rx_took) begin
      rx_wait = $urandom_range(0, 7);
      out_tready <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      out_tready <= (rx_wait == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    point_t e;
    rx_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result beat %h/%b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        e = expected_points.pop_front();
        if (out_tdata[31:0] !== e.px) begin
          $error("point_x exp %0d got %0d", $signed(e.px), $signed(out_tdata[31:0]));
          fail_count++;
        end
        if (out_tdata[63:32] !== e.py) begin
          $error("point_y exp %0d got %0d", $signed(e.py), $signed(out_tdata[63:32]));
          fail_count++;
        end
        if (out_tdata[79:64] !== e.pz) begin
          $error("point_z exp %0d got %0d", e.pz, out_tdata[79:64]);
          fail_count++;
        end
        if (out_tuser[0] !== e.pvalid) begin
          $error("point_valid exp %0b got %0b", e.pvalid, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== e.fend) begin
          $error("frame_end exp %0b got %0b", e.fend, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed_pixels();
    send_pixel(16'd1, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'd0, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'd0, 1'b1);
    send_pixel(16'd1234, 1'b0);
    send_pixel(16'd0, 1'b1);
  endtask

  // tiny and extreme intrinsics, including zero focal and narrow rows
  task automatic test_register_extremes();
    write_reg(REG_FOCAL_X, 20'd0);
    write_reg(REG_FOCAL_Y, 20'd256);
    write_reg(REG_CENTER_X, 20'hFFFFF);
    write_reg(REG_CENTER_Y, 20'd0);
    write_reg(REG_IMAGE_WIDTH, 20'd1);
    for (int i = 0; i < 6; i++) send_pixel(i[0] ? 16'hFFFF : 16'd7, 1'b0);
    send_pixel(16'd0, 1'b1);
    write_reg(REG_IMAGE_WIDTH, 20'd0);
    write_reg(REG_FOCAL_X, 20'hFFFFF);
    write_reg(REG_FOCAL_Y, 20'd0);
    write_reg(REG_CENTER_X, 20'd0);
    write_reg(REG_CENTER_Y, 20'hFFFFF);
    for (int i = 0; i < 4; i++) send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'd9, 1'b1);
  endtask

  // random frames over several settings
  task automatic test_random_frames();
    int left;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_FOCAL_X, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_FOCAL_Y, 20'($urandom_range(256, 4000)));
      write_reg(REG_CENTER_X, 20'($urandom_range(0, 20'hFFFFF)));
      write_reg(REG_CENTER_Y, 20'($urandom_range(0, 3000)));
      write_reg(REG_IMAGE_WIDTH, 20'($urandom_range(1, 12)));
      left = 150;
      while (left > 0) begin
        logic [15:0] z;
        z = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        send_pixel(z, $urandom_range(0, 19) == 0);
        left--;
      end
    end
  endtask

  // hold the receiver off so the block backs up and stalls its input
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_pixel(16'($urandom_range(1, 65535)), i == 11);
    join
  endtask

  initial begin
    fx = FOCAL_X_RST; fy = FOCAL_Y_RST; cx = CENTER_X_RST; cy = CENTER_Y_RST;
    img_w = IMG_W_RST; col_cnt = 0; row_cnt = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_pixels();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    in_tvalid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (200) @(negedge clk);
    if (fail_count == 0) $display("PASS depth_to_point_backprojection");
    else $display("FAIL depth_to_point_backprojection");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dpb_pkg.sv
hw/rtl/dpb_front.sv
hw/rtl/dpb_queue.sv
hw/rtl/dpb_divider.sv
hw/rtl/dpb_back.sv
hw/rtl/depth_to_point_backprojection.sv
hw/rtl/dpb_checker.sv
test/testbench.sv
